/* rtl/tts_pkg.sv */
`default_nettype none

package tts_pkg;

    // Table geometry; the slot index is the low bits of the key, so the
    // entry count must be a power of two
    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int KEY_W   = 64;
    localparam int SCORE_W = 16;
    localparam int DEPTH_W = 8;
    localparam int BOUND_W = 2;
    localparam int MOVE_W  = 16;
    localparam int AGE_W   = 8;

    typedef enum logic {
        ACT_PROBE = 1'b0,
        ACT_STORE = 1'b1
    } t_action;

    // One table slot, 114 bits
    typedef struct packed {
        logic        [KEY_W-1:0]   key;
        logic signed [SCORE_W-1:0] score;
        logic signed [DEPTH_W-1:0] depth;
        logic        [BOUND_W-1:0] bound;
        logic        [MOVE_W-1:0]  move;
        logic        [AGE_W-1:0]   age;
    } t_entry;

    // Write port of the table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           data;
    } t_tbl_wr;

endpackage

`default_nettype wire

/* rtl/tts_table.sv */
`default_nettype none

module tts_table (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rd_en,
    input  wire logic [tts_pkg::IDX_W-1:0] i_rd_idx,
    output      tts_pkg::t_entry       o_rd_data,
    input  wire tts_pkg::t_tbl_wr      i_wr,
    output      logic                  o_busy
);
    import tts_pkg::*;

    t_entry           r_mem [TABLE_ENTRIES];
    t_entry           r_rd_data;
    logic             r_busy;
    logic [IDX_W-1:0] r_clr_idx;

    // Clearing sweep after reset: one slot per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Single write port, shared by the sweep and the request path
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
    end

    // Registered read; returns the old contents on a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

`default_nettype wire

/* rtl/transposition_table_store_probe_unit.sv */
`default_nettype none
// A request is held in stage 1; its result is registered when stage 1 advances.
// Throughput: one request per cycle while o_in_stall is low; the table read, compare
// and write-back of a request take one stage, with forwarding from the write of the preceding request.
// Reset: synchronous; after reset a clearing sweep zeroes all TABLE_ENTRIES slots,
// one per cycle, while o_in_stall is high. Config writes are always taken.

module transposition_table_store_probe_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [tts_pkg::AGE_W-1:0]     i_cfg_data,
    // request channel
    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire logic                          i_action,
    input  wire logic [tts_pkg::KEY_W-1:0]     i_position_key,
    input  wire logic signed [tts_pkg::SCORE_W-1:0] i_new_score,
    input  wire logic signed [tts_pkg::DEPTH_W-1:0] i_new_depth,
    input  wire logic [tts_pkg::BOUND_W-1:0]   i_new_bound,
    input  wire logic [tts_pkg::MOVE_W-1:0]    i_new_move,
    // result channel
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output      logic                          o_hit,
    output      logic signed [tts_pkg::SCORE_W-1:0] o_entry_score,
    output      logic signed [tts_pkg::DEPTH_W-1:0] o_entry_depth,
    output      logic [tts_pkg::BOUND_W-1:0]   o_entry_bound,
    output      logic [tts_pkg::MOVE_W-1:0]    o_entry_move,
    output      logic                          o_replaced
);
    import tts_pkg::*;

    logic [AGE_W-1:0] r_cur_age;

    // stage 1 request
    logic                 r_s1_valid;
    t_action              r_s1_action;
    logic [KEY_W-1:0]     r_s1_key;
    t_entry               r_s1_new;
    logic                 r_s1_fwd;
    t_entry               r_fwd_ent;

    // output register
    logic                 r_out_valid;
    logic                 r_hit;
    logic signed [SCORE_W-1:0] r_score;
    logic signed [DEPTH_W-1:0] r_depth;
    logic [BOUND_W-1:0]   r_bound;
    logic [MOVE_W-1:0]    r_move;
    logic                 r_replaced;

    logic                 n_hit;
    logic                 n_replaced;

    logic                 tbl_busy;
    t_entry               rd_data;
    t_entry               ent;
    t_tbl_wr              wr;
    logic                 in_acc;
    logic                 s1_adv;
    logic [IDX_W-1:0]     in_idx;
    logic [AGE_W-1:0]     prev_age;
    logic                 key_eq;
    logic                 do_wr;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_age <= '0;
        end else if (i_cfg_valid) begin
            r_cur_age <= i_cfg_data;
        end
    end

    // Handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = tbl_busy || (r_s1_valid && !s1_adv);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_idx     = i_position_key[IDX_W-1:0];

    tts_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_idx  (in_idx),
        .o_rd_data (rd_data),
        .i_wr      (wr),
        .o_busy    (tbl_busy)
    );

    // Stage 1 capture; forward a write to the same slot on the read edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_action    <= t_action'(i_action);
            r_s1_key       <= i_position_key;
            r_s1_new.key   <= i_position_key;
            r_s1_new.score <= i_new_score;
            r_s1_new.depth <= i_new_depth;
            r_s1_new.bound <= i_new_bound;
            r_s1_new.move  <= i_new_move;
            r_s1_new.age   <= '0;
            r_s1_fwd       <= wr.en && (wr.idx == in_idx);
            r_fwd_ent      <= wr.data;
        end
    end

    // Slot contents seen by the stage 1 request
    assign ent      = r_s1_fwd ? r_fwd_ent : rd_data;
    assign prev_age = r_cur_age - 1'b1;
    assign key_eq   = (ent.key == r_s1_key);

    // Replacement and hit decisions
    always_comb begin
        do_wr      = !key_eq || (r_s1_new.depth >= ent.depth) || (ent.age != r_cur_age);
        n_hit      = 1'b0;
        n_replaced = 1'b0;
        unique case (r_s1_action)
            ACT_STORE: n_replaced = do_wr;
            ACT_PROBE: n_hit = key_eq && ((ent.age == r_cur_age) || (ent.age == prev_age));
            default:   n_hit = 1'b0;
        endcase
    end

    // Write-back of a replacing store
    always_comb begin
        wr          = '0;
        wr.en       = s1_adv && n_replaced;
        wr.idx      = r_s1_key[IDX_W-1:0];
        wr.data     = r_s1_new;
        wr.data.age = r_cur_age;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_hit      <= n_hit;
            r_replaced <= n_replaced;
            r_score    <= n_hit ? ent.score : '0;
            r_depth    <= n_hit ? ent.depth : '0;
            r_bound    <= n_hit ? ent.bound : '0;
            r_move     <= n_hit ? ent.move  : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_entry_score = r_score;
    assign o_entry_depth = r_depth;
    assign o_entry_bound = r_bound;
    assign o_entry_move  = r_move;
    assign o_replaced    = r_replaced;

endmodule

`default_nettype wire

/* sim/transposition_table_store_probe_unit_tb.sv */
`default_nettype none

module transposition_table_store_probe_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int HOLDOFF_AT     = 700;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int PHASE_REQS     = 241;
    localparam int KEY_POOL_SIZE  = 48;

    typedef struct packed {
        t_action                   action;
        logic        [KEY_W-1:0]   key;
        logic signed [SCORE_W-1:0] score;
        logic signed [DEPTH_W-1:0] depth;
        logic        [BOUND_W-1:0] bound;
        logic        [MOVE_W-1:0]  move;
    } t_request;

    typedef struct packed {
        logic                      hit;
        logic signed [SCORE_W-1:0] score;
        logic signed [DEPTH_W-1:0] depth;
        logic        [BOUND_W-1:0] bound;
        logic        [MOVE_W-1:0]  move;
        logic                      replaced;
    } t_lookup;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic [AGE_W-1:0]   cfg_data  = '0;
    logic               cfg_ready;

    logic               req_valid = 1'b0;
    t_request           req_cur   = '0;
    logic               req_stall;

    logic               res_valid;
    logic               res_stall = 1'b0;
    wire t_lookup       res_got;

    // shadow of the table and the search age
    t_entry             shadow_table [TABLE_ENTRIES];
    logic [AGE_W-1:0]   search_age = '0;

    t_request           pending_reqs [$];
    t_lookup            expected_lookups [$];
    logic [KEY_W-1:0]   key_pool [KEY_POOL_SIZE];

    int unsigned        accepted_reqs = 0;
    int unsigned        mismatches    = 0;
    int unsigned        cycle_count   = 0;
    int unsigned        holdoff_left  = 0;
    logic               holdoff_done  = 1'b0;

    wire steady_stretch = accepted_reqs >= 1200 && accepted_reqs < 1500;

    transposition_table_store_probe_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (req_valid),
        .o_in_stall     (req_stall),
        .i_action       (req_cur.action),
        .i_position_key (req_cur.key),
        .i_new_score    (req_cur.score),
        .i_new_depth    (req_cur.depth),
        .i_new_bound    (req_cur.bound),
        .i_new_move     (req_cur.move),
        .o_out_valid    (res_valid),
        .i_out_stall    (res_stall),
        .o_hit          (res_got.hit),
        .o_entry_score  (res_got.score),
        .o_entry_depth  (res_got.depth),
        .o_entry_bound  (res_got.bound),
        .o_entry_move   (res_got.move),
        .o_replaced     (res_got.replaced)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Probe or store against the shadow table; returns the expected result
    function automatic t_lookup access_table(t_request r);
        t_lookup          res;
        logic [IDX_W-1:0] idx;
        logic [AGE_W-1:0] prev_age;
        t_entry           slot;
        res      = '0;
        idx      = r.key[IDX_W-1:0];
        slot     = shadow_table[idx];
        prev_age = search_age - 1'b1;
        if (r.action == ACT_STORE) begin
            if (slot.key != r.key || $signed(r.depth) >= $signed(slot.depth) ||
                slot.age != search_age) begin
                slot.key   = r.key;
                slot.score = r.score;
                slot.depth = r.depth;
                slot.bound = r.bound;
                slot.move  = r.move;
                slot.age   = search_age;
                shadow_table[idx] = slot;
                res.replaced = 1'b1;
            end
        end else if (slot.key == r.key && (slot.age == search_age || slot.age == prev_age)) begin
            res.hit   = 1'b1;
            res.score = slot.score;
            res.depth = slot.depth;
            res.bound = slot.bound;
            res.move  = slot.move;
        end
        return res;
    endfunction

    task automatic queue_req(t_action act, logic [KEY_W-1:0] key, logic [SCORE_W-1:0] score,
                             logic [DEPTH_W-1:0] depth, logic [BOUND_W-1:0] bound,
                             logic [MOVE_W-1:0] move);
        t_request r;
        r.action = act;
        r.key    = key;
        r.score  = score;
        r.depth  = depth;
        r.bound  = bound;
        r.move   = move;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Request driver: holds the payload while stalled, idles at random
    always @(posedge i_clk) begin : req_driver
        t_request nxt;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && !req_stall) begin
                expected_lookups.insert(expected_lookups.size(), access_table(req_cur));
                accepted_reqs <= accepted_reqs + 1;
            end
            if (!req_valid || !req_stall) begin
                if (pending_reqs.size() != 0 &&
                    (steady_stretch || $urandom_range(99) >= 10)) begin
                    nxt = pending_reqs.pop_front();
                    req_cur   <= nxt;
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: random, plus one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_stall    <= 1'b0;
            holdoff_left <= 0;
        end else if (holdoff_left != 0) begin
            res_stall    <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && accepted_reqs >= HOLDOFF_AT) begin
            res_stall    <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end else begin
            res_stall <= !steady_stretch && $urandom_range(99) < 10;
        end
    end

    // Result checker
    always @(posedge i_clk) begin : res_monitor
        t_lookup exp_res;
        if (i_rst_n && res_valid && !res_stall) begin
            if (expected_lookups.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"unexpected result: hit=%0b score=%0d depth=%0d bound=%0d",
                              " move=%h repl=%0b"},
                             res_got.hit, res_got.score, res_got.depth, res_got.bound,
                             res_got.move, res_got.replaced);
            end else begin
                exp_res = expected_lookups.pop_front();
                if (res_got.hit !== exp_res.hit || res_got.score !== exp_res.score ||
                    res_got.depth !== exp_res.depth || res_got.bound !== exp_res.bound ||
                    res_got.move !== exp_res.move || res_got.replaced !== exp_res.replaced) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"mismatch exp: hit=%0b score=%0d depth=%0d bound=%0d",
                                  " move=%h repl=%0b"},
                                 exp_res.hit, exp_res.score, exp_res.depth, exp_res.bound,
                                 exp_res.move, exp_res.replaced);
                        $display({"         got: hit=%0b score=%0d depth=%0d bound=%0d",
                                  " move=%h repl=%0b"},
                                 res_got.hit, res_got.score, res_got.depth, res_got.bound,
                                 res_got.move, res_got.replaced);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[transposition_table_store_probe_unit] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [AGE_W-1:0] phase_ages [8];
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] odd_key;
        phase_ages = '{8'd0, 8'd1, 8'd255, 8'd0, 8'd1, 8'd128, 8'd129, 8'd255};
        odd_key    = {1'b1, {(KEY_W-IDX_W-1){1'b0}}, {IDX_W{1'b1}}};

        foreach (shadow_table[i]) shadow_table[i] = '0;

        // keys crowd onto a few slots so stores collide and probes hit
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = KEY_W'(TABLE_ENTRIES);
        for (int i = 3; i < KEY_POOL_SIZE; i++) begin
            key = {$urandom, $urandom};
            key[IDX_W-1:0] = IDX_W'($urandom_range(15) * 257);
            key_pool[i] = key;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 8; p++) begin
            // age update only while nothing is in flight
            @(posedge i_clk);
            cfg_valid <= 1'b1;
            cfg_data  <= phase_ages[p];
            do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
            search_age = phase_ages[p];
            cfg_valid <= 1'b0;

            if (p == 0) begin
                // empty slot is key 0 at age 0; other key in slot 0 misses
                queue_req(ACT_PROBE, '0, 16'sh7fff, 8'sd127, 2'd3, 16'hffff);
                queue_req(ACT_PROBE, KEY_W'(TABLE_ENTRIES), '0, '0, '0, '0);
                // extremes, bound code three, equal and lower depth
                queue_req(ACT_STORE, '1, 16'sh8000, 8'sh80, 2'd3, 16'hffff);
                queue_req(ACT_PROBE, '1, '0, '0, '0, '0);
                queue_req(ACT_STORE, '1, 16'sh7fff, 8'sh80, 2'd0, 16'h0000);
                queue_req(ACT_STORE, '1, 16'sd1, 8'sd127, 2'd1, 16'h5a5a);
                queue_req(ACT_STORE, '1, 16'sd2, 8'sd126, 2'd2, 16'h1234);
                queue_req(ACT_STORE, '1, 16'sd3, 8'sh80, 2'd2, 16'h4321);
                queue_req(ACT_PROBE, '1, '0, '0, '0, '0);
                // different key on the same slot always wins
                queue_req(ACT_STORE, odd_key, -16'sd7, 8'sh80, 2'd2, 16'haaaa);
                queue_req(ACT_PROBE, '1, '0, '0, '0, '0);
                queue_req(ACT_PROBE, odd_key, '0, '0, '0, '0);
                queue_req(ACT_STORE, '0, 16'sh7fff, 8'sd127, 2'd2, 16'haaaa);
                queue_req(ACT_STORE, KEY_W'(TABLE_ENTRIES), 16'sh8000, 8'sh80, 2'd1, 16'h5555);
                queue_req(ACT_PROBE, '0, '0, '0, '0, '0);
                queue_req(ACT_PROBE, KEY_W'(TABLE_ENTRIES), '0, '0, '0, '0);
                queue_req(ACT_PROBE, 64'h5555_5555_5555_5555, 16'h5555, 8'h55, 2'd1, 16'h5555);
            end

            for (int n = 0; n < PHASE_REQS; n++) begin
                if ($urandom_range(99) < 85)
                    key = key_pool[$urandom_range(KEY_POOL_SIZE-1)];
                else
                    key = {$urandom, $urandom};
                queue_req(t_action'($urandom_range(1)), key, SCORE_W'($urandom),
                          DEPTH_W'($urandom), BOUND_W'($urandom_range(3)), MOVE_W'($urandom));
            end

            // drain before the next age change
            do @(posedge i_clk);
            while (pending_reqs.size() != 0 || req_valid || expected_lookups.size() != 0);
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_lookups.size() == 0)
            $display("[transposition_table_store_probe_unit] OK");
        else
            $display("[transposition_table_store_probe_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* transposition_table_store_probe_unit.f */
rtl/tts_pkg.sv
rtl/tts_table.sv
rtl/transposition_table_store_probe_unit.sv
sim/transposition_table_store_probe_unit_tb.sv
